// ===== hw/rtl/ofq_pkg.sv =====
package ofq_pkg;

   // fixed widths of the channel fields
   localparam int CMD_W     = 2;
   localparam int CLASS_W   = 2;
   localparam int STATUS_W  = 2;
   localparam int PORT_PAY_W   = 16;
   localparam int PORT_STAMP_W = 32;

   // depth of the request queue between front and back
   localparam int FRONT_DEPTH = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ_ANY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEQ_B   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DEQ_A   = 2'd3;

   // item class codes on the request channel
   localparam logic [CLASS_W-1:0] CLS_A = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_B = 2'd1;

   // class bit on the response channel
   localparam logic OUT_CLS_A = 1'b0;
   localparam logic OUT_CLS_B = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

   // decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_ENQ_A,
      OP_ENQ_B,
      OP_ENQ_OTHER,
      OP_DEQ_ANY,
      OP_DEQ_A,
      OP_DEQ_B
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    out_class;
      logic [PORT_PAY_W-1:0]   out_payload;
      logic [PORT_STAMP_W-1:0] out_stamp;
   } res_type;

endpackage

// ===== hw/rtl/ofq_if.sv =====
interface ofq_req_if;
   logic                          valid;
   logic                          ready;
   logic [ofq_pkg::CMD_W-1:0]     command;
   logic [ofq_pkg::CLASS_W-1:0]   item_class;
   logic [ofq_pkg::PORT_PAY_W-1:0] item_payload;

   modport source (output valid, input ready, output command, output item_class,
                   output item_payload);
   modport sink   (input valid, output ready, input command, input item_class,
                   input item_payload);
endinterface

interface ofq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ofq_pkg::STATUS_W-1:0]     status;
   logic                             out_class;
   logic [ofq_pkg::PORT_PAY_W-1:0]   out_payload;
   logic [ofq_pkg::PORT_STAMP_W-1:0] out_stamp;

   modport source (output valid, input ready, output status, output out_class,
                   output out_payload, output out_stamp);
   modport sink   (input valid, output ready, input status, input out_class,
                   input out_payload, input out_stamp);
endinterface

// ===== hw/rtl/ofq_ram.sv =====
module ofq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ofq_front.sv =====
module ofq_front #(
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   ofq_req_if.sink                 req_chan,
   output ofq_pkg::cmd_type        cmd,
   output logic [PAYLOAD_BITS-1:0] cmd_payload,
   input  logic                    cmd_ready
);

   localparam int CNT_W = $clog2(ofq_pkg::FRONT_DEPTH + 1);

   ofq_pkg::op_type           op_ff  [ofq_pkg::FRONT_DEPTH];
   logic [PAYLOAD_BITS-1:0]   pay_ff [ofq_pkg::FRONT_DEPTH];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   ofq_pkg::op_type           req_op;
   logic                      push, pop;

   // classify the incoming request
   always_comb begin
      req_op = ofq_pkg::OP_DEQ_ANY;
      unique case (req_chan.command)
         ofq_pkg::CMD_ENQUEUE: begin
            if (req_chan.item_class == ofq_pkg::CLS_A) begin
               req_op = ofq_pkg::OP_ENQ_A;
            end else if (req_chan.item_class == ofq_pkg::CLS_B) begin
               req_op = ofq_pkg::OP_ENQ_B;
            end else begin
               req_op = ofq_pkg::OP_ENQ_OTHER;
            end
         end
         ofq_pkg::CMD_DEQ_ANY: req_op = ofq_pkg::OP_DEQ_ANY;
         ofq_pkg::CMD_DEQ_B:   req_op = ofq_pkg::OP_DEQ_B;
         ofq_pkg::CMD_DEQ_A:   req_op = ofq_pkg::OP_DEQ_A;
         default:              req_op = ofq_pkg::OP_DEQ_ANY;
      endcase
   end

   assign req_chan.ready = (count_ff != CNT_W'(ofq_pkg::FRONT_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = cmd.valid && cmd_ready;

   assign cmd.valid   = (count_ff != '0);
   assign cmd.op      = op_ff[rd_ptr_ff];
   assign cmd_payload = pay_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]  <= req_op;
         pay_ff[wr_ptr_ff] <= PAYLOAD_BITS'(req_chan.item_payload);
      end
   end

endmodule

// ===== hw/rtl/ofq_back.sv =====
module ofq_back #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 16,
   parameter int STAMP_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ofq_pkg::cmd_type        cmd,
   input  logic [PAYLOAD_BITS-1:0] cmd_payload,
   output logic                    cmd_ready,
   output logic                    res_valid,
   output ofq_pkg::res_type        res,
   input  logic                    res_ready
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);
   localparam int ENT_W = STAMP_BITS + PAYLOAD_BITS;

   ofq_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]      a_head_ff, a_head_in, b_head_ff, b_head_in;
   logic [CNT_W-1:0]      a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;

   logic [SUM_W-1:0]      a_sum, b_sum;
   logic [IDX_W-1:0]      a_slot, b_slot;
   logic [ENT_W-1:0]      a_rd, b_rd, wr_entry;
   logic [STAMP_BITS-1:0] stamp_diff;
   logic                  a_empty, b_empty, a_full, b_full, take_a, is_enq;
   logic                  a_push, b_push, a_pop, b_pop, stamp_adv;

   // tail slot of each class FIFO
   assign a_sum  = SUM_W'(a_head_ff) + SUM_W'(a_count_ff);
   assign b_sum  = SUM_W'(b_head_ff) + SUM_W'(b_count_ff);
   assign a_slot = (a_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(a_sum - SUM_W'(QUEUE_DEPTH))
                                                  : IDX_W'(a_sum);
   assign b_slot = (b_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(b_sum - SUM_W'(QUEUE_DEPTH))
                                                  : IDX_W'(b_sum);

   assign wr_entry = {cmd_payload, stamp_ff};

   ofq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_push),
      .wr_addr (a_slot),
      .wr_data (wr_entry),
      .rd_addr (a_head_ff),
      .rd_data (a_rd)
   );

   ofq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_push),
      .wr_addr (b_slot),
      .wr_data (wr_entry),
      .rd_addr (b_head_ff),
      .rd_data (b_rd)
   );

   assign a_empty = (a_count_ff == '0);
   assign b_empty = (b_count_ff == '0);
   assign a_full  = (a_count_ff == CNT_W'(QUEUE_DEPTH));
   assign b_full  = (b_count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_enq  = cmd.op inside {ofq_pkg::OP_ENQ_A, ofq_pkg::OP_ENQ_B,
                                   ofq_pkg::OP_ENQ_OTHER};

   // A is older when the wrapped difference is negative; ties go to B
   assign stamp_diff = a_rd[STAMP_BITS-1:0] - b_rd[STAMP_BITS-1:0];

   always_comb begin
      take_a = 1'b1;
      unique case (cmd.op)
         ofq_pkg::OP_DEQ_A: take_a = 1'b1;
         ofq_pkg::OP_DEQ_B: take_a = 1'b0;
         default: begin
            if (b_empty) begin
               take_a = 1'b1;
            end else if (a_empty) begin
               take_a = 1'b0;
            end else begin
               take_a = stamp_diff[STAMP_BITS-1];
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ofq_pkg::S_IDLE: begin
            if (cmd.valid && !is_enq) begin
               state_in = ofq_pkg::S_READ;
            end
         end
         ofq_pkg::S_READ: begin
            if (res_ready) begin
               state_in = ofq_pkg::S_IDLE;
            end
         end
         default: state_in = ofq_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      a_push    = 1'b0;
      b_push    = 1'b0;
      a_pop     = 1'b0;
      b_pop     = 1'b0;
      stamp_adv = 1'b0;
      unique case (state_ff)
         ofq_pkg::S_IDLE: begin
            if (cmd.valid && is_enq) begin
               res_valid = 1'b1;
               cmd_ready = res_ready;
               unique case (cmd.op)
                  ofq_pkg::OP_ENQ_A: begin
                     res.out_class = ofq_pkg::OUT_CLS_A;
                     if (a_full) begin
                        res.status = ofq_pkg::ST_FULL;
                     end else begin
                        res.status    = ofq_pkg::ST_OK;
                        res.out_stamp = ofq_pkg::PORT_STAMP_W'(stamp_ff);
                        a_push        = res_ready;
                        stamp_adv     = res_ready;
                     end
                  end
                  ofq_pkg::OP_ENQ_B: begin
                     res.out_class = ofq_pkg::OUT_CLS_B;
                     if (b_full) begin
                        res.status = ofq_pkg::ST_FULL;
                     end else begin
                        res.status    = ofq_pkg::ST_OK;
                        res.out_stamp = ofq_pkg::PORT_STAMP_W'(stamp_ff);
                        b_push        = res_ready;
                        stamp_adv     = res_ready;
                     end
                  end
                  default: begin
                     res.status    = ofq_pkg::ST_UNKNOWN;
                     res.out_stamp = ofq_pkg::PORT_STAMP_W'(stamp_ff);
                     stamp_adv     = res_ready;
                  end
               endcase
            end
         end
         ofq_pkg::S_READ: begin
            res_valid = 1'b1;
            cmd_ready = res_ready;
            if (take_a) begin
               if (a_empty) begin
                  res.status = ofq_pkg::ST_EMPTY;
               end else begin
                  res.status      = ofq_pkg::ST_OK;
                  res.out_class   = ofq_pkg::OUT_CLS_A;
                  res.out_payload = ofq_pkg::PORT_PAY_W'(a_rd[ENT_W-1:STAMP_BITS]);
                  res.out_stamp   = ofq_pkg::PORT_STAMP_W'(a_rd[STAMP_BITS-1:0]);
                  a_pop           = res_ready;
               end
            end else begin
               if (b_empty) begin
                  res.status = ofq_pkg::ST_EMPTY;
               end else begin
                  res.status      = ofq_pkg::ST_OK;
                  res.out_class   = ofq_pkg::OUT_CLS_B;
                  res.out_payload = ofq_pkg::PORT_PAY_W'(b_rd[ENT_W-1:STAMP_BITS]);
                  res.out_stamp   = ofq_pkg::PORT_STAMP_W'(b_rd[STAMP_BITS-1:0]);
                  b_pop           = res_ready;
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // head and count updates
   always_comb begin
      a_head_in  = a_head_ff;
      b_head_in  = b_head_ff;
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      stamp_in   = stamp_adv ? stamp_ff + STAMP_BITS'(1) : stamp_ff;
      if (a_push) begin
         a_count_in = a_count_ff + CNT_W'(1);
      end else if (a_pop) begin
         a_count_in = a_count_ff - CNT_W'(1);
         a_head_in  = (a_head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : a_head_ff + IDX_W'(1);
      end
      if (b_push) begin
         b_count_in = b_count_ff + CNT_W'(1);
      end else if (b_pop) begin
         b_count_in = b_count_ff - CNT_W'(1);
         b_head_in  = (b_head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : b_head_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ofq_pkg::S_IDLE;
         a_head_ff  <= '0;
         b_head_ff  <= '0;
         a_count_ff <= '0;
         b_count_ff <= '0;
         stamp_ff   <= STAMP_BITS'(1);
      end else begin
         state_ff   <= state_in;
         a_head_ff  <= a_head_in;
         b_head_ff  <= b_head_in;
         a_count_ff <= a_count_in;
         b_count_ff <= b_count_in;
         stamp_ff   <= stamp_in;
      end
   end

endmodule

// ===== hw/rtl/oldest_first_two_class_queue_core.sv =====
// An accepted request is registered in the front queue; the back answers an enqueue into
// the response register, and a dequeue after the registered read of the class stores (head
// read, then compare and pop). One enqueue per cycle while the response side does not
// stall; the back takes no new request until a dequeue is answered.
// Reset (synchronous, active high) empties both class FIFOs, the request queue and the
// response register and sets the arrival stamp to 1; store contents are not cleared.
module oldest_first_two_class_queue_core #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 16,
   parameter int STAMP_BITS   = 32
) (
   input logic        clock,
   input logic        reset,
   ofq_req_if.sink    req_chan,
   ofq_rsp_if.source  rsp_chan
);

   // front -> back: decoded request waiting in a two-entry queue
   ofq_pkg::cmd_type        cmd;
   logic [PAYLOAD_BITS-1:0] cmd_payload;
   logic                    cmd_ready;

   // back -> response register
   logic                    res_valid;
   logic                    res_ready;
   ofq_pkg::res_type        res;

   // response register: lets the back retire a request while the
   // previous response still waits for the consumer
   logic                    rsp_valid_ff, rsp_valid_in;
   ofq_pkg::res_type        rsp_data_ff;

   // front: accept and classify requests, hold them until the back is free
   ofq_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cmd         (cmd),
      .cmd_payload (cmd_payload),
      .cmd_ready   (cmd_ready)
   );

   // back: class FIFOs, arrival stamps and the oldest-first pick
   ofq_back #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .STAMP_BITS   (STAMP_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_payload (cmd_payload),
      .cmd_ready   (cmd_ready),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   // take a new response when the register is empty or drains this cycle
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while stalled, load on every transfer from the back
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.out_class   = rsp_data_ff.out_class;
   assign rsp_chan.out_payload = rsp_data_ff.out_payload;
   assign rsp_chan.out_stamp   = rsp_data_ff.out_stamp;

endmodule
